[hdl/ascii85_encoder_unit_macros.svh]
// Assertion helpers for the ASCII85 encoder.
// Both sample on aclk and are off while aresetn is low.
`ifndef ASCII85_ENCODER_UNIT_MACROS_SVH
`define ASCII85_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication
`define A85_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define A85_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/a85_pkg.sv]
`default_nettype none

package a85_pkg;

    // Field widths
    localparam int A85_BYTE_W  = 8;
    localparam int A85_GROUP_W = 32;
    localparam int A85_DIGIT_W = 7;
    localparam int A85_NDIG_W  = 3;
    localparam int A85_DIGITS  = 5;

    // Character offset and largest legal character
    localparam logic [A85_DIGIT_W-1:0] A85_OFFSET   = 7'd33;
    localparam logic [A85_DIGIT_W-1:0] A85_CHAR_MAX = 7'd117;

    // Digit weights, most significant first (85^4 .. 85^1)
    localparam int unsigned A85_WEIGHT_0 = 52200625;
    localparam int unsigned A85_WEIGHT_1 = 614125;
    localparam int unsigned A85_WEIGHT_2 = 7225;
    localparam int unsigned A85_WEIGHT_3 = 85;

    // Bytes held in the open group before the incoming one
    localparam logic [1:0] A85_HELD_NONE  = 2'd0;
    localparam logic [1:0] A85_HELD_ONE   = 2'd1;
    localparam logic [1:0] A85_HELD_TWO   = 2'd2;
    localparam logic [1:0] A85_HELD_THREE = 2'd3;

    // One closed group: left-aligned, zero padded, with its character count
    typedef struct packed {
        logic [A85_GROUP_W-1:0] group;
        logic [A85_NDIG_W-1:0]  ndigits;
    } a85_group_t;

endpackage

`default_nettype wire

[hdl/a85_front.sv]
`default_nettype none

module a85_front
    import a85_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [A85_BYTE_W-1:0] s_data_byte,
    input  wire logic                  s_end_of_data,
    input  wire logic                  q_full,
    output logic                       q_push,
    output a85_group_t                 q_data
);

    logic [23:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        accept;
    logic        closes;

    // Take a byte whenever the queue can hold a closed group
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign closes  = (held_count_reg == A85_HELD_THREE) || s_end_of_data;
    assign q_push  = accept && closes;

    // Left-align the group and pad the missing bytes with zero
    always_comb begin
        q_data.ndigits = A85_NDIG_W'(held_count_reg) + A85_NDIG_W'(2);
        unique case (held_count_reg)
            A85_HELD_NONE:  q_data.group = {s_data_byte, 24'd0};
            A85_HELD_ONE:   q_data.group = {held_bytes_reg[7:0], s_data_byte, 16'd0};
            A85_HELD_TWO:   q_data.group = {held_bytes_reg[15:0], s_data_byte, 8'd0};
            A85_HELD_THREE: q_data.group = {held_bytes_reg, s_data_byte};
            default:        q_data.group = '0;
        endcase
    end

    // Gather bytes of the open group
    always_comb begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept) begin
            if (closes) begin
                held_bytes_next = '0;
                held_count_next = A85_HELD_NONE;
            end else begin
                held_bytes_next = {held_bytes_reg[15:0], s_data_byte};
                held_count_next = held_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bytes_reg <= '0;
            held_count_reg <= A85_HELD_NONE;
        end else begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/a85_fifo.sv]
`default_nettype none

module a85_fifo
    import a85_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire a85_group_t push_data,
    output logic            full,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output a85_group_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    a85_group_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/a85_digit_stage.sv]
`default_nettype none

// One base-85 digit: quotient by reciprocal multiply, then remainder.
module a85_digit_stage
    import a85_pkg::*;
#(
    parameter int          IN_W   = 32,
    parameter int unsigned WEIGHT = 52200625,
    parameter int          SIDE_W = 3,
    parameter int          REM_W  = $clog2(WEIGHT)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   advance,
    input  wire logic                   in_valid,
    input  wire logic [IN_W-1:0]        in_rem,
    input  wire logic [SIDE_W-1:0]      in_side,
    output logic                        out_valid,
    output logic [A85_DIGIT_W-1:0]      out_digit,
    output logic [REM_W-1:0]            out_rem,
    output logic [SIDE_W-1:0]           out_side
);

    // floor(v / WEIGHT) == (v * RECIP) >> SHIFT for every v below 2^IN_W
    localparam int              SHIFT      = IN_W + $clog2(WEIGHT);
    localparam int              RECIP_W    = IN_W + 1;
    localparam int              PROD_W     = IN_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WEIGHT) - 64'd1) / 64'(WEIGHT);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
    localparam logic [IN_W-1:0]    WEIGHT_V = IN_W'(WEIGHT);

    logic [PROD_W-1:0]      prod;
    logic [IN_W-1:0]        diff;

    logic                   valid_a_reg;
    logic [A85_DIGIT_W-1:0] quot_a_reg;
    logic [IN_W-1:0]        rem_a_reg;
    logic [SIDE_W-1:0]      side_a_reg;

    logic                   valid_b_reg;
    logic [A85_DIGIT_W-1:0] digit_b_reg;
    logic [REM_W-1:0]       rem_b_reg;
    logic [SIDE_W-1:0]      side_b_reg;

    // Quotient estimate, exact by choice of RECIP
    assign prod = PROD_W'(in_rem) * PROD_W'(RECIP);

    // Remainder after taking out the digit
    assign diff = rem_a_reg - IN_W'(quot_a_reg) * WEIGHT_V;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (advance) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            quot_a_reg  <= prod[SHIFT +: A85_DIGIT_W];
            rem_a_reg   <= in_rem;
            side_a_reg  <= in_side;
            digit_b_reg <= quot_a_reg;
            rem_b_reg   <= diff[REM_W-1:0];
            side_b_reg  <= side_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_digit = digit_b_reg;
    assign out_rem   = rem_b_reg;
    assign out_side  = side_b_reg;

endmodule

`default_nettype wire

[hdl/a85_back.sv]
`default_nettype none

module a85_back
    import a85_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    output logic                        q_ready,
    input  wire a85_group_t             q_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [A85_DIGIT_W-1:0]      m_out_char,
    output logic                        m_run_last
);

    localparam int SIDE_W0 = A85_NDIG_W;
    localparam int SIDE_W1 = SIDE_W0 + A85_DIGIT_W;
    localparam int SIDE_W2 = SIDE_W1 + A85_DIGIT_W;
    localparam int SIDE_W3 = SIDE_W2 + A85_DIGIT_W;
    localparam int REM_W0  = $clog2(A85_WEIGHT_0);
    localparam int REM_W1  = $clog2(A85_WEIGHT_1);
    localparam int REM_W2  = $clog2(A85_WEIGHT_2);
    localparam int REM_W3  = $clog2(A85_WEIGHT_3);

    logic                   advance;
    logic                   ser_free;
    logic                   load;

    logic                   v0, v1, v2, v3;
    logic [A85_DIGIT_W-1:0] d0, d1, d2, d3;
    logic [REM_W0-1:0]      r0;
    logic [REM_W1-1:0]      r1;
    logic [REM_W2-1:0]      r2;
    logic [REM_W3-1:0]      r3;
    logic [SIDE_W0-1:0]     side0;
    logic [SIDE_W1-1:0]     side1;
    logic [SIDE_W2-1:0]     side2;
    logic [SIDE_W3-1:0]     side3;

    logic [A85_DIGIT_W-1:0] char_reg [A85_DIGITS];
    logic [A85_DIGIT_W-1:0] char_next [A85_DIGITS];
    logic [A85_NDIG_W-1:0]  cnt_reg, cnt_next;

    // Whole digit pipeline moves together; it holds only when its last
    // group cannot enter the output shifter
    assign ser_free = (cnt_reg == '0) || (m_ready && cnt_reg == A85_NDIG_W'(1));
    assign advance  = !v3 || ser_free;
    assign load     = v3 && advance;
    assign q_ready  = advance;

    a85_digit_stage #(
        .IN_W   (A85_GROUP_W),
        .WEIGHT (A85_WEIGHT_0),
        .SIDE_W (SIDE_W0)
    ) u_stage0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (q_valid),
        .in_rem    (q_data.group),
        .in_side   (q_data.ndigits),
        .out_valid (v0),
        .out_digit (d0),
        .out_rem   (r0),
        .out_side  (side0)
    );

    a85_digit_stage #(
        .IN_W   (REM_W0),
        .WEIGHT (A85_WEIGHT_1),
        .SIDE_W (SIDE_W1)
    ) u_stage1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (v0),
        .in_rem    (r0),
        .in_side   ({side0, d0}),
        .out_valid (v1),
        .out_digit (d1),
        .out_rem   (r1),
        .out_side  (side1)
    );

    a85_digit_stage #(
        .IN_W   (REM_W1),
        .WEIGHT (A85_WEIGHT_2),
        .SIDE_W (SIDE_W2)
    ) u_stage2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (v1),
        .in_rem    (r1),
        .in_side   ({side1, d1}),
        .out_valid (v2),
        .out_digit (d2),
        .out_rem   (r2),
        .out_side  (side2)
    );

    a85_digit_stage #(
        .IN_W   (REM_W2),
        .WEIGHT (A85_WEIGHT_3),
        .SIDE_W (SIDE_W3)
    ) u_stage3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (v2),
        .in_rem    (r2),
        .in_side   ({side2, d2}),
        .out_valid (v3),
        .out_digit (d3),
        .out_rem   (r3),
        .out_side  (side3)
    );

    // Output shifter: load five characters, send the first ndigits of them
    always_comb begin
        for (int i = 0; i < A85_DIGITS; i++) begin
            char_next[i] = char_reg[i];
        end
        cnt_next = cnt_reg;
        if (load) begin
            char_next[0] = side3[SIDE_W3-A85_NDIG_W-1 -: A85_DIGIT_W] + A85_OFFSET;
            char_next[1] = side3[2*A85_DIGIT_W-1 -: A85_DIGIT_W] + A85_OFFSET;
            char_next[2] = side3[A85_DIGIT_W-1:0] + A85_OFFSET;
            char_next[3] = d3 + A85_OFFSET;
            char_next[4] = A85_DIGIT_W'(r3) + A85_OFFSET;
            cnt_next     = side3[SIDE_W3-1 -: A85_NDIG_W];
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < A85_DIGITS - 1; i++) begin
                char_next[i] = char_reg[i+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < A85_DIGITS; i++) begin
            char_reg[i] <= char_next[i];
        end
    end

    assign m_valid    = (cnt_reg != '0);
    assign m_out_char = char_reg[0];
    assign m_run_last = (cnt_reg == A85_NDIG_W'(1));

endmodule

`default_nettype wire

[hdl/ascii85_encoder_unit.sv]
// Path: after acceptance, a byte that closes a group passes the queue, four two-register
//   digit stages and the output shifter load before its first character shows on m_.
// Throughput: one character per cycle while m_ready is high; the output shifter takes
//   the next group as the last character of the current one is sent.
// Reset: aresetn synchronous, active low; clears the open group, queue and output valid.
`default_nettype none

`include "ascii85_encoder_unit_macros.svh"

module ascii85_encoder_unit
    import a85_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [A85_BYTE_W-1:0]  s_data_byte,
    input  wire logic                   s_end_of_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [A85_DIGIT_W-1:0]      m_out_char,
    output logic                        m_run_last
);

    logic       q_full;
    logic       q_push;
    a85_group_t q_in;
    logic       q_valid;
    logic       q_ready;
    a85_group_t q_out;

    // Byte gathering
    a85_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_end_of_data (s_end_of_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    // Closed groups waiting for conversion
    a85_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_out)
    );

    // Base-85 conversion and character output
    a85_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_out),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_run_last (m_run_last)
    );

    // Checks
    `A85_ASSERT_IMP(a_no_overflow, q_push, !q_full, "group pushed into a full queue")
    `A85_ASSERT_IMP(a_char_range, m_valid,
                    (m_out_char >= A85_OFFSET) && (m_out_char <= A85_CHAR_MAX),
                    "output character outside the base-85 range")
    `A85_ASSERT_NXT(a_run_unbroken, m_valid && m_ready && !m_run_last, m_valid,
                    "gap inside a character run")

endmodule

`default_nettype wire
